// ===== src/bldc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bldc_pkg;

    localparam logic [7:0]  SYNC0     = 8'hAA;
    localparam logic [7:0]  SYNC1     = 8'h44;
    localparam logic [7:0]  SYNC2     = 8'h12;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [16:0] CRC_BYTES = 17'd4;

    localparam logic [16:0] POS_HDR_LEN = 17'd3;
    localparam logic [16:0] POS_ID_LO   = 17'd4;
    localparam logic [16:0] POS_ID_HI   = 17'd5;
    localparam logic [16:0] POS_BODY_LO = 17'd8;
    localparam logic [16:0] POS_BODY_HI = 17'd9;
    localparam logic [16:0] MIN_TOTAL   = 17'd10;

    typedef enum logic [1:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_HUNT2,
        ST_FRAME
    } bldc_state_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic [16:0] idx;
        logic        first;
        logic        last;
        logic        ok;
        logic [15:0] id;
    } bldc_entry_t;

endpackage

`default_nettype wire

// ===== src/bldc_crc32.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bldc_crc32 (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic [31:0]      crc_out
);
    import bldc_pkg::*;

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ===== src/bldc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bldc_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    output bldc_pkg::bldc_entry_t  leaving
);
    import bldc_pkg::*;

    bldc_state_t state_reg, state_next;
    logic [16:0] pos_reg, pos_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [15:0] body_reg, body_next;
    logic [15:0] type_reg, type_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] rx_reg, rx_next;
    bldc_entry_t pipe0_reg, pipe0_next;
    bldc_entry_t pipe1_reg, pipe1_next;

    logic [31:0] crc_folded;
    logic        sync_hit;
    logic        in_frame;
    logic        frame_end;
    logic        frame_ok;
    logic [16:0] total;
    logic [7:0]  hdr_f;
    logic [15:0] body_f;
    logic [15:0] type_f;
    logic [31:0] run_f;
    logic [31:0] rx_f;
    bldc_entry_t cur;
    bldc_entry_t sync0_entry;
    bldc_entry_t sync1_entry;

    bldc_crc32 u_crc (
        .crc_in  (run_reg),
        .data_in (rx_reg[7:0]),
        .crc_out (crc_folded)
    );

    assign in_frame = (state_reg == ST_FRAME);
    assign sync_hit = (state_reg == ST_HUNT2) && (data_byte == SYNC2);

    // frame-byte datapath
    always_comb
    begin
        run_f  = (pos_reg >= CRC_BYTES) ? crc_folded : run_reg;
        rx_f   = {data_byte, rx_reg[31:8]};
        hdr_f  = (pos_reg == POS_HDR_LEN) ? data_byte : hdr_reg;
        type_f = type_reg;
        body_f = body_reg;
        case (pos_reg)
            POS_ID_LO:   type_f = {8'd0, data_byte};
            POS_ID_HI:   type_f = {data_byte, type_reg[7:0]};
            POS_BODY_LO: body_f = {8'd0, data_byte};
            POS_BODY_HI: body_f = {data_byte, body_reg[7:0]};
            default:     ;
        endcase
        total     = {9'd0, hdr_f} + {1'b0, body_f} + CRC_BYTES;
        frame_end = in_frame && (pos_reg >= POS_BODY_HI) &&
                    ((total < MIN_TOTAL) || (pos_reg >= total - 17'd1));
        frame_ok  = (total >= MIN_TOTAL) && (run_f == rx_f);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT1:
            begin
                if (data_byte == SYNC1)
                    state_next = ST_HUNT2;
                else if (data_byte == SYNC0)
                    state_next = ST_HUNT1;
                else
                    state_next = ST_HUNT0;
            end
            ST_HUNT2:
            begin
                if (data_byte == SYNC2)
                    state_next = ST_FRAME;
                else if (data_byte == SYNC0)
                    state_next = ST_HUNT1;
                else
                    state_next = ST_HUNT0;
            end
            ST_FRAME:
            begin
                state_next = frame_end ? ST_HUNT0 : ST_FRAME;
            end
            default:
            begin
                state_next = (data_byte == SYNC0) ? ST_HUNT1 : ST_HUNT0;
            end
        endcase
    end

    // outputs and registers
    always_comb
    begin
        sync0_entry       = '0;
        sync0_entry.valid = 1'b1;
        sync0_entry.data  = SYNC0;
        sync0_entry.first = 1'b1;
        sync1_entry       = '0;
        sync1_entry.valid = 1'b1;
        sync1_entry.data  = SYNC1;
        sync1_entry.idx   = 17'd1;

        cur       = '0;
        cur.valid = in_frame || sync_hit;
        cur.data  = data_byte;
        cur.idx   = sync_hit ? 17'd2 : pos_reg;
        cur.last  = frame_end;
        cur.ok    = frame_end && frame_ok;
        cur.id    = frame_end ? type_f : 16'd0;

        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        body_next = body_reg;
        type_next = type_reg;
        run_next  = run_reg;
        rx_next   = rx_reg;
        if (sync_hit)
        begin
            pos_next  = POS_HDR_LEN;
            hdr_next  = '0;
            body_next = '0;
            type_next = '0;
            run_next  = '0;
            rx_next   = {SYNC2, SYNC1, SYNC0, 8'd0};
        end
        else if (in_frame)
        begin
            pos_next  = frame_end ? 17'd0 : pos_reg + 17'd1;
            hdr_next  = hdr_f;
            body_next = body_f;
            type_next = type_f;
            run_next  = run_f;
            rx_next   = rx_f;
        end

        if (sync_hit)
        begin
            leaving    = sync0_entry;
            pipe0_next = sync1_entry;
        end
        else
        begin
            leaving    = pipe0_reg;
            pipe0_next = pipe1_reg;
        end
        pipe1_next = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT0;
            pos_reg   <= '0;
            hdr_reg   <= '0;
            body_reg  <= '0;
            type_reg  <= '0;
            run_reg   <= '0;
            rx_reg    <= '0;
            pipe0_reg <= '0;
            pipe1_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            body_reg  <= body_next;
            type_reg  <= type_next;
            run_reg   <= run_next;
            rx_reg    <= rx_next;
            pipe0_reg <= pipe0_next;
            pipe1_reg <= pipe1_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/binary_log_deframer_crc32_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid/in_ready    data_byte
// output    out_valid/out_ready  frame_byte, byte_index, frame_first, frame_last,
//                                crc_ok, message_id
//
// One byte per cycle while in_ready is high; CRC fold and compare are combinational, ahead of the delay line.
// Each frame byte leaves two input words after it enters (two-entry delay line);
// the first sync byte leaves with the word that completes the sync.
// Reset clears the hunt state, the delay line and the output register.
// in_ready drops only while the output register holds a word not taken.

module binary_log_deframer_crc32_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       frame_byte,
    output logic [16:0]      byte_index,
    output logic             frame_first,
    output logic             frame_last,
    output logic             crc_ok,
    output logic [15:0]      message_id
);
    import bldc_pkg::*;

    logic        step;
    bldc_entry_t leaving;
    logic        out_valid_reg, out_valid_next;
    bldc_entry_t out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    bldc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (data_byte),
        .leaving   (leaving)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = leaving.valid;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold payload until a new word replaces it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (step && leaving.valid)
        begin
            out_reg <= leaving;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = out_reg.data;
    assign byte_index  = out_reg.idx;
    assign frame_first = out_reg.first;
    assign frame_last  = out_reg.last;
    assign crc_ok      = out_reg.ok;
    assign message_id  = out_reg.id;

endmodule

`default_nettype wire
